[src/tcd_pkg.sv]
package tcd_pkg;

  localparam int CFG_DIM_W   = 13;
  localparam int COLS_W      = 6;
  localparam int COORD_W     = 12;
  localparam int NUM_W       = 11;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [NUM_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_TILE_WIDTH  = 3'd1,
    REG_TILE_HEIGHT = 3'd2,
    REG_TILE_COLS   = 3'd3,
    REG_TILE_ROWS   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    KIND_TILE  = 1'b0,
    KIND_TOTAL = 1'b1
  } result_kind_e;

  // effective geometry, zero sizes and limits already applied
  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] tile_width;
    logic [CFG_DIM_W-1:0] tile_height;
    logic [COLS_W-1:0]    tile_cols;
    logic [COLS_W-1:0]    tile_rows;
  } tcd_cfg_t;

  // per tile row job, dirty flags travel next to it
  typedef struct packed {
    logic [COORD_W-1:0] tile_y;
    logic               total;
    logic               fresh;
  } job_info_t;

endpackage

[src/tcd_queue.sv]
module tcd_queue
  import tcd_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue read while empty");
`endif

endmodule

[src/tcd_front.sv]
module tcd_front
  import tcd_pkg::*;
#(
  parameter int MAX_TILE_COLS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tcd_cfg_t                 cfg,
  input  logic                     accept,
  input  logic [PIX_W-1:0]         current_pixel,
  input  logic [PIX_W-1:0]         previous_pixel,
  input  logic                     start_of_frame,
  output logic                     push,
  output logic [MAX_TILE_COLS-1:0] push_flags,
  output job_info_t                push_info
);

  logic [CFG_DIM_W-1:0]     pixel_column;
  logic [CFG_DIM_W-1:0]     column_in_tile;
  logic [CFG_DIM_W-1:0]     line_in_tile;
  logic [COLS_W-1:0]        tile_col_index;
  logic [COLS_W-1:0]        tile_row_index;
  logic [MAX_TILE_COLS-1:0] dirty_flags;
  logic                     fresh;

  logic [CFG_DIM_W-1:0]     pixel_column_next;
  logic [CFG_DIM_W-1:0]     column_in_tile_next;
  logic [CFG_DIM_W-1:0]     line_in_tile_next;
  logic [COLS_W-1:0]        tile_col_index_next;
  logic [COLS_W-1:0]        tile_row_index_next;
  logic [MAX_TILE_COLS-1:0] dirty_flags_next;
  logic                     fresh_next;

  // values after a start of frame clear
  logic [CFG_DIM_W-1:0]     pc_c;
  logic [CFG_DIM_W-1:0]     cit_c;
  logic [CFG_DIM_W-1:0]     lit_c;
  logic [COLS_W-1:0]        tci_c;
  logic [COLS_W-1:0]        tri_c;
  logic [MAX_TILE_COLS-1:0] flags_c;
  logic                     fresh_c;
  logic [MAX_TILE_COLS-1:0] flags_upd;
  logic                     col_ok;
  logic                     row_ok;
  logic [CFG_DIM_W:0]       pc_inc;
  logic [CFG_DIM_W:0]       cit_inc;
  logic [CFG_DIM_W:0]       lit_inc;
  logic [COLS_W:0]          tri_inc;
  logic                     row_end;
  logic [COLS_W+COORD_W-1:0] origin_prod;
  logic [MAX_TILE_COLS-1:0] col_mask;

  always_comb begin
    pc_c     = start_of_frame ? '0 : pixel_column;
    cit_c    = start_of_frame ? '0 : column_in_tile;
    lit_c    = start_of_frame ? '0 : line_in_tile;
    tci_c    = start_of_frame ? '0 : tile_col_index;
    tri_c    = start_of_frame ? '0 : tile_row_index;
    flags_c  = start_of_frame ? '0 : dirty_flags;
    fresh_c  = start_of_frame ? 1'b1 : fresh;

    row_ok  = (tri_c < cfg.tile_rows);
    col_ok  = (tci_c < cfg.tile_cols);
    pc_inc  = {1'b0, pc_c} + (CFG_DIM_W+1)'(1);
    cit_inc = {1'b0, cit_c} + (CFG_DIM_W+1)'(1);
    lit_inc = {1'b0, lit_c} + (CFG_DIM_W+1)'(1);
    tri_inc = {1'b0, tri_c} + (COLS_W+1)'(1);

    flags_upd = flags_c;
    if (row_ok && col_ok && (current_pixel != previous_pixel)) begin
      flags_upd = flags_c | (MAX_TILE_COLS'(1) << tci_c);
    end

    pixel_column_next   = pixel_column;
    column_in_tile_next = column_in_tile;
    line_in_tile_next   = line_in_tile;
    tile_col_index_next = tile_col_index;
    tile_row_index_next = tile_row_index;
    dirty_flags_next    = dirty_flags;
    fresh_next          = fresh;
    row_end             = 1'b0;

    if (accept) begin
      column_in_tile_next = cit_c;
      tile_col_index_next = tci_c;
      line_in_tile_next   = lit_c;
      tile_row_index_next = tri_c;
      dirty_flags_next    = flags_upd;
      fresh_next          = fresh_c;

      if (col_ok) begin
        if (cit_inc >= {1'b0, cfg.tile_width}) begin
          column_in_tile_next = '0;
          tile_col_index_next = tci_c + COLS_W'(1);
        end else begin
          column_in_tile_next = cit_inc[CFG_DIM_W-1:0];
        end
      end

      if (pc_inc < {1'b0, cfg.frame_width}) begin
        pixel_column_next = pc_inc[CFG_DIM_W-1:0];
      end else begin
        // end of line
        pixel_column_next   = '0;
        column_in_tile_next = '0;
        tile_col_index_next = '0;
        if (row_ok) begin
          if (lit_inc < {1'b0, cfg.tile_height}) begin
            line_in_tile_next = lit_inc[CFG_DIM_W-1:0];
          end else begin
            row_end             = 1'b1;
            line_in_tile_next   = '0;
            dirty_flags_next    = '0;
            tile_row_index_next = tri_inc[COLS_W-1:0];
            fresh_next          = 1'b0;
          end
        end
      end
    end
  end

  // origin line from the current tile height, wrapped to the coordinate width
  assign origin_prod = tri_c * cfg.tile_height[COORD_W-1:0];
  // only columns of the current grid are reported
  assign col_mask    = (MAX_TILE_COLS'(1) << cfg.tile_cols) - MAX_TILE_COLS'(1);

  assign push             = row_end;
  assign push_flags       = flags_upd & col_mask;
  assign push_info.tile_y = origin_prod[COORD_W-1:0];
  assign push_info.total  = (tri_inc >= {1'b0, cfg.tile_rows});
  assign push_info.fresh  = fresh_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column   <= '0;
      column_in_tile <= '0;
      line_in_tile   <= '0;
      tile_col_index <= '0;
      tile_row_index <= '0;
      dirty_flags    <= '0;
      fresh          <= 1'b1;
    end else begin
      pixel_column   <= pixel_column_next;
      column_in_tile <= column_in_tile_next;
      line_in_tile   <= line_in_tile_next;
      tile_col_index <= tile_col_index_next;
      tile_row_index <= tile_row_index_next;
      dirty_flags    <= dirty_flags_next;
      fresh          <= fresh_next;
    end
  end

endmodule

[src/tcd_back.sv]
module tcd_back
  import tcd_pkg::*;
#(
  parameter int MAX_TILE_COLS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tcd_cfg_t                 cfg,
  input  logic                     job_valid,
  input  logic [MAX_TILE_COLS-1:0] job_flags,
  input  job_info_t                job_info,
  output logic                     job_pop,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     kind,
  output logic [COORD_W-1:0]       tile_x,
  output logic [COORD_W-1:0]       tile_y,
  output logic [NUM_W-1:0]         tile_number,
  output logic                     last
);

  localparam int PROD_W = COLS_W + COORD_W;

  logic                     busy;
  logic [MAX_TILE_COLS-1:0] flags;
  logic [COORD_W-1:0]       row_y;
  logic                     total;
  logic [NUM_W-1:0]         count;

  logic                     busy_next;
  logic [MAX_TILE_COLS-1:0] flags_next;
  logic [COORD_W-1:0]       row_y_next;
  logic                     total_next;
  logic [NUM_W-1:0]         count_next;
  logic                     result_valid_next;
  logic                     kind_next;
  logic [COORD_W-1:0]       tile_x_next;
  logic [COORD_W-1:0]       tile_y_next;
  logic [NUM_W-1:0]         tile_number_next;
  logic                     last_next;

  logic                     out_free;
  logic [COLS_W-1:0]        low_idx;
  logic [MAX_TILE_COLS-1:0] rest;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         count_inc;

  // lowest dirty column
  always_comb begin
    low_idx = '0;
    for (int i = MAX_TILE_COLS - 1; i >= 0; i--) begin
      if (flags[i]) begin
        low_idx = COLS_W'(i);
      end
    end
  end

  assign rest      = flags & (flags - MAX_TILE_COLS'(1));
  assign prod      = low_idx * cfg.tile_width[COORD_W-1:0];
  assign count_inc = (count == COUNT_MAX) ? count : count + NUM_W'(1);
  assign out_free  = !result_valid || !result_stall;
  assign job_pop   = !busy && job_valid;

  always_comb begin
    busy_next         = busy;
    flags_next        = flags;
    row_y_next        = row_y;
    total_next        = total;
    count_next        = count;
    result_valid_next = result_valid && result_stall;
    kind_next         = kind;
    tile_x_next       = tile_x;
    tile_y_next       = tile_y;
    tile_number_next  = tile_number;
    last_next         = last;

    if (job_pop) begin
      flags_next = job_flags;
      row_y_next = job_info.tile_y;
      total_next = job_info.total;
      busy_next  = (job_flags != '0) || job_info.total;
      if (job_info.fresh) begin
        count_next = '0;
      end
    end else if (busy && out_free) begin
      result_valid_next = 1'b1;
      if (flags != '0) begin
        kind_next        = KIND_TILE;
        tile_x_next      = prod[COORD_W-1:0];
        tile_y_next      = row_y;
        tile_number_next = count;
        last_next        = (rest == '0) && !total;
        count_next       = count_inc;
        flags_next       = rest;
        busy_next        = (rest != '0) || total;
      end else begin
        kind_next        = KIND_TOTAL;
        tile_x_next      = '0;
        tile_y_next      = '0;
        tile_number_next = count;
        last_next        = 1'b1;
        busy_next        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      busy         <= busy_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    flags       <= flags_next;
    row_y       <= row_y_next;
    total       <= total_next;
    kind        <= kind_next;
    tile_x      <= tile_x_next;
    tile_y      <= tile_y_next;
    tile_number <= tile_number_next;
    last        <= last_next;
  end

`ifndef SYNTHESIS
  a_total_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_TOTAL) |-> (last && tile_x == '0 && tile_y == '0))
    else $error("total report malformed");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !job_pop)
    else $error("job taken while previous job still running");
`endif

endmodule

[src/tile_change_detector_unit.sv]
// tile change detector
// pixel channel: pixel_valid / pixel_stall carry one transaction per pixel pair
// (current_pixel, previous_pixel, start_of_frame) in raster order; start_of_frame
// clears the position, the dirty flags and the frame count before that pixel counts
// result channel: result_valid / result_stall carry dirty tile reports (kind 0,
// origin and running ordinal) and, after the last tile row, one total (kind 1);
// last marks the final result caused by the pixel that closed a tile row
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, always ready;
// write only while the block is idle
// throughput: the front end takes one pixel per cycle; a closing tile row puts a
// job in a four entry queue, and the pixel input stalls only while it is full
// the back end loads a job from the queue only while idle, then reports each dirty tile
// in turn and the total; each result is held in a registered output stage
// result_stall holds the output register and, once the queue fills, the input
// reset (rst, synchronous) clears position, flags, count, queue and output valid,
// and loads the register defaults 1920 / 60 / 34 / 32 / 32
module tile_change_detector_unit
  import tcd_pkg::*;
#(
  parameter int MAX_TILE_COLS   = 32,
  parameter int MAX_FRAME_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIX_W-1:0]      current_pixel,
  input  logic [PIX_W-1:0]      previous_pixel,
  input  logic                  start_of_frame,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  kind,
  output logic [COORD_W-1:0]    tile_x,
  output logic [COORD_W-1:0]    tile_y,
  output logic [NUM_W-1:0]      tile_number,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int JOB_W = MAX_TILE_COLS + $bits(job_info_t);

  // configuration registers as written
  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] tile_width;
  logic [CFG_DIM_W-1:0] tile_height;
  logic [COLS_W-1:0]    tile_cols;
  logic [COLS_W-1:0]    tile_rows;

  tcd_cfg_t             cfg_eff;
  logic [CFG_DIM_W-1:0] fw_min1;

  logic                     accept;
  logic                     push;
  logic [MAX_TILE_COLS-1:0] push_flags;
  job_info_t                push_info;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  logic [JOB_W-1:0]         q_data;
  logic [MAX_TILE_COLS-1:0] job_flags;
  job_info_t                job_info;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= CFG_DIM_W'(1920);
      tile_width  <= CFG_DIM_W'(60);
      tile_height <= CFG_DIM_W'(34);
      tile_cols   <= COLS_W'(32);
      tile_rows   <= COLS_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        REG_TILE_WIDTH:  tile_width  <= cfg_data;
        REG_TILE_HEIGHT: tile_height <= cfg_data;
        REG_TILE_COLS:   tile_cols   <= cfg_data[COLS_W-1:0];
        REG_TILE_ROWS:   tile_rows   <= cfg_data[COLS_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // zero sizes act as one, wide frames and column counts are clamped
  always_comb begin
    fw_min1 = (frame_width == '0) ? CFG_DIM_W'(1) : frame_width;
    cfg_eff.frame_width = (32'(fw_min1) > MAX_FRAME_WIDTH) ?
                          CFG_DIM_W'(MAX_FRAME_WIDTH) : fw_min1;
    cfg_eff.tile_width  = (tile_width == '0) ? CFG_DIM_W'(1) : tile_width;
    cfg_eff.tile_height = (tile_height == '0) ? CFG_DIM_W'(1) : tile_height;
    cfg_eff.tile_cols   = (32'(tile_cols) > MAX_TILE_COLS) ?
                          COLS_W'(MAX_TILE_COLS) : tile_cols;
    cfg_eff.tile_rows   = tile_rows;
  end

  // input waits only when the job queue has no room
  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !pixel_stall;

  tcd_front #(
    .MAX_TILE_COLS(MAX_TILE_COLS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_eff),
    .accept        (accept),
    .current_pixel (current_pixel),
    .previous_pixel(previous_pixel),
    .start_of_frame(start_of_frame),
    .push          (push),
    .push_flags    (push_flags),
    .push_info     (push_info)
  );

  tcd_queue #(
    .W(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_flags, push_info}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  assign job_flags = q_data[JOB_W-1 -: MAX_TILE_COLS];
  assign job_info  = q_data[$bits(job_info_t)-1:0];

  tcd_back #(
    .MAX_TILE_COLS(MAX_TILE_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_eff),
    .job_valid   (q_valid),
    .job_flags   (job_flags),
    .job_info    (job_info),
    .job_pop     (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind        (kind),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_number (tile_number),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> pixel_stall)
    else $error("pixel taken with job queue full");
`endif

endmodule
